### src/pid_speed_controller_defines.svh
// ----------------------------------------------------------------------------
// pid_speed_controller_defines
// assertion macros shared by the speed controller modules
// ----------------------------------------------------------------------------
`ifndef PID_SPEED_CONTROLLER_DEFINES_SVH
`define PID_SPEED_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// implication or plain property checked on every rising clock edge out of reset
`define PSC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("psc assertion failed");
// condition that must never be true
`define PSC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("psc forbidden condition seen");
`else
`define PSC_ASSERT(lbl, clk, rst_n, prop)
`define PSC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// types, register codes and saturating helpers of the pid speed controller
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int MUL_W     = 32;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int CFG_IDX_W = 3;

	typedef logic [MUL_W-1:0]     mul_op_t;
	typedef logic [2*MUL_W-1:0]   mul_prod_t;
	typedef logic [DIV_NUM_W-1:0] div_num_t;
	typedef logic [DIV_DEN_W-1:0] div_den_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PROP_GAIN  = 3'd0;
	localparam cfg_idx_t REG_INTEG_GAIN = 3'd1;
	localparam cfg_idx_t REG_DERIV_GAIN = 3'd2;
	localparam cfg_idx_t REG_OUT_LOWER  = 3'd3;
	localparam cfg_idx_t REG_OUT_UPPER  = 3'd4;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic signed [31:0] PROP_GAIN_RESET  = 32'sd65536;
	localparam logic signed [31:0] INTEG_GAIN_RESET = 32'sd0;
	localparam logic signed [31:0] DERIV_GAIN_RESET = 32'sd0;
	localparam logic signed [31:0] OUT_LOWER_RESET  = 32'sd0;
	localparam logic signed [31:0] OUT_UPPER_RESET  = 32'sd65536;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_PROP,
		S_ACC_MUL,
		S_ACC_ADD,
		S_DIV_LO,
		S_DIV_HI,
		S_ORDER,
		S_CLAMP_LO,
		S_CLAMP_HI,
		S_IMUL_HI,
		S_IMUL_LO,
		S_ITERM,
		S_ISIGN,
		S_DMUL_HI,
		S_DDIV,
		S_DWAIT,
		S_SUM_PI,
		S_SUM_D,
		S_LIM_LO,
		S_LIM_HI
	} psc_state_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// signed value from magnitude and sign, saturated to 64 bits
	function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
		logic signed [63:0] r;
		if (neg) begin
			r = m[63] ? S64_MIN : -$signed(m);
		end else begin
			r = m[63] ? S64_MAX : $signed(m);
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? S64_MIN : S64_MAX;
		end
		return s;
	endfunction

endpackage

### src/psc_mul.sv
// ----------------------------------------------------------------------------
// psc_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module psc_mul (
	input  logic                clk,
	input  psc_pkg::mul_op_t    a,
	input  psc_pkg::mul_op_t    b,
	output psc_pkg::mul_prod_t  prod
);
	import psc_pkg::*;

	mul_prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_prod_t'(a) * mul_prod_t'(b);
	end

	assign prod = prod_q;

endmodule

### src/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "pid_speed_controller_defines.svh"

module psc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  psc_pkg::div_num_t   num,
	input  psc_pkg::div_den_t   den,
	output psc_pkg::div_stat_t  stat,
	output psc_pkg::div_num_t   quo
);
	import psc_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_NUM_W);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	div_num_t         num_q;
	div_den_t         den_q;
	div_den_t         rem_q;
	div_num_t         quo_q;

	logic [DIV_DEN_W:0] trial;
	logic               take;
	div_den_t           rem_next;
	logic               launch;

	assign launch = start && !busy_q;

	always_comb begin
		trial    = {rem_q, num_q[DIV_NUM_W-1]};
		take     = trial >= {1'b0, den_q};
		rem_next = take ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LOAD;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_ONE;
				if (cnt_q == CNT_ONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

	`PSC_ASSERT(a_launch_busy, clk, arst_n, launch |=> busy_q)
	`PSC_ASSERT(a_last_done, clk, arst_n, (busy_q && cnt_q == CNT_ONE) |=> (done_q && !busy_q))
	`PSC_ASSERT(a_rem_below, clk, arst_n, (busy_q && den_q != '0) |-> (rem_q < den_q))

endmodule

### src/pid_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_speed_controller
// fixed-point pid speed loop with integral clamp anti-windup.
// input channel (in_valid/in_ready) takes one word: command, target, measured,
// step_time. command clear wipes the integral, last error and first-run flag
// and gives no result. a step word gives one drive word on the output channel
// (out_valid/out_ready), held in an output register.
// config channel (cfg_valid/cfg_ready) writes gains and limits by index and
// also wipes the controller state; it is taken only while the block is idle.
// one shared 32x32 multiplier and one 1-bit-per-cycle divider do the work.
// when integ_gain is nonzero, two divisions find the integral clamp bounds;
// when the derivative term is active, one division by step_time follows.
// a new word is accepted the cycle after the result is loaded.
// a stalled receiver holds the result; the next word is still accepted and
// runs until its own result is ready, then waits for the register to free.
// reset loads the register defaults and clears the controller state.
// ----------------------------------------------------------------------------
`include "pid_speed_controller_defines.svh"

module pid_speed_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic signed [31:0]         target,
	input  logic signed [31:0]         measured,
	input  logic [15:0]                step_time,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         drive,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                cfg_data
);
	import psc_pkg::*;

	psc_state_t state_q;
	psc_state_t state_d;

	logic signed [31:0] kp_q;
	logic signed [31:0] ki_q;
	logic signed [31:0] kd_q;
	logic signed [31:0] lower_q;
	logic signed [31:0] upper_q;

	logic signed [63:0] acc_q;
	logic signed [32:0] last_q;
	logic               fresh_q;

	logic signed [32:0] err_q;
	logic [15:0]        dt_q;
	logic signed [33:0] diff_q;
	logic signed [63:0] p_q;
	logic signed [63:0] i_q;
	logic signed [63:0] d_q;
	logic signed [63:0] t_q;
	logic signed [63:0] blo_q;
	logic signed [63:0] bhi_q;
	logic [63:0]        imag_q;
	logic signed [31:0] drive_q;
	logic               out_valid_q;

	mul_op_t   mul_a;
	mul_op_t   mul_b;
	mul_prod_t mul_prod;
	logic      div_start;
	div_num_t  div_num;
	div_den_t  div_den;
	div_num_t  div_quo;
	div_stat_t div_stat;

	logic               in_fire;
	logic               cfg_fire;
	logic               state_clear;
	logic               load_out;
	logic [32:0]        err_mag;
	logic [33:0]        diff_mag;
	logic [63:0]        acc_mag;
	logic [31:0]        kp_mag;
	logic [31:0]        ki_mag;
	logic [31:0]        kd_mag;
	logic signed [63:0] acc_res;
	logic signed [63:0] acc_sum;
	logic signed [63:0] lower_ext;
	logic signed [63:0] upper_ext;

	psc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	psc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// magnitudes and extended limits
	always_comb begin
		err_mag   = err_q[32] ? -err_q : err_q;
		diff_mag  = diff_q[33] ? -diff_q : diff_q;
		acc_mag   = mag64(acc_q);
		kp_mag    = mag32(kp_q);
		ki_mag    = mag32(ki_q);
		kd_mag    = mag32(kd_q);
		lower_ext = {{32{lower_q[31]}}, lower_q};
		upper_ext = {{32{upper_q[31]}}, upper_q};
	end

	// integral update, saturating add or subtract of |err| * dt
	always_comb begin
		acc_res = err_q[32] ? acc_q - $signed(mul_prod) : acc_q + $signed(mul_prod);
		acc_sum = acc_res;
		if (!err_q[32] && !acc_q[63] && acc_res[63]) begin
			acc_sum = S64_MAX;
		end else if (err_q[32] && acc_q[63] && !acc_res[63]) begin
			acc_sum = S64_MIN;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && command == CMD_STEP) begin
					state_d = S_PROP;
				end
			end
			S_PROP:     state_d = S_ACC_MUL;
			S_ACC_MUL:  state_d = S_ACC_ADD;
			S_ACC_ADD:  state_d = (ki_q != '0) ? S_DIV_LO : S_IMUL_HI;
			S_DIV_LO: begin
				if (div_stat.done) begin
					state_d = S_DIV_HI;
				end
			end
			S_DIV_HI: begin
				if (div_stat.done) begin
					state_d = S_ORDER;
				end
			end
			S_ORDER:    state_d = S_CLAMP_LO;
			S_CLAMP_LO: state_d = S_CLAMP_HI;
			S_CLAMP_HI: state_d = S_IMUL_HI;
			S_IMUL_HI:  state_d = S_IMUL_LO;
			S_IMUL_LO:  state_d = S_ITERM;
			S_ITERM:    state_d = S_ISIGN;
			S_ISIGN:    state_d = (fresh_q || dt_q == '0) ? S_SUM_PI : S_DMUL_HI;
			S_DMUL_HI:  state_d = S_DDIV;
			S_DDIV:     state_d = S_DWAIT;
			S_DWAIT: begin
				if (div_stat.done) begin
					state_d = S_SUM_PI;
				end
			end
			S_SUM_PI:   state_d = S_SUM_D;
			S_SUM_D:    state_d = S_LIM_LO;
			S_LIM_LO:   state_d = S_LIM_HI;
			S_LIM_HI: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer: handshakes and shared unit operands
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		load_out  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cfg_ready = 1'b1;
			end
			S_PROP: begin
				mul_a = kp_mag;
				mul_b = err_mag[31:0];
			end
			S_ACC_MUL: begin
				mul_a = err_mag[31:0];
				mul_b = {16'b0, dt_q};
			end
			S_ACC_ADD: begin
				div_start = ki_q != '0;
				div_num   = {mag32(lower_q), 32'b0};
				div_den   = ki_mag;
			end
			S_DIV_LO: begin
				div_start = div_stat.done;
				div_num   = {mag32(upper_q), 32'b0};
				div_den   = ki_mag;
			end
			S_IMUL_HI: begin
				mul_a = acc_mag[63:32];
				mul_b = ki_mag;
			end
			S_IMUL_LO: begin
				mul_a = acc_mag[31:0];
				mul_b = ki_mag;
			end
			S_ISIGN: begin
				mul_a = kd_mag;
				mul_b = diff_mag[31:0];
			end
			S_DMUL_HI: begin
				mul_a = kd_mag;
				mul_b = {30'b0, diff_mag[33:32]};
			end
			S_DDIV: begin
				// the full product stays below 2^64, so the high part fits
				div_start = 1'b1;
				div_num   = imag_q + {mul_prod[31:0], 32'b0};
				div_den   = {16'b0, dt_q};
			end
			S_LIM_HI: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign in_fire     = in_valid && in_ready;
	assign cfg_fire    = cfg_valid && cfg_ready;
	assign state_clear = (cfg_fire && cfg_index <= REG_OUT_UPPER)
		|| (in_fire && command == CMD_CLEAR);

	// control state, registers and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kp_q        <= PROP_GAIN_RESET;
			ki_q        <= INTEG_GAIN_RESET;
			kd_q        <= DERIV_GAIN_RESET;
			lower_q     <= OUT_LOWER_RESET;
			upper_q     <= OUT_UPPER_RESET;
			acc_q       <= '0;
			last_q      <= '0;
			fresh_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_PROP_GAIN:  kp_q    <= cfg_data;
					REG_INTEG_GAIN: ki_q    <= cfg_data;
					REG_DERIV_GAIN: kd_q    <= cfg_data;
					REG_OUT_LOWER:  lower_q <= cfg_data;
					REG_OUT_UPPER:  upper_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_ACC_ADD:  acc_q <= acc_sum;
				S_CLAMP_LO: begin
					if (acc_q < blo_q) begin
						acc_q <= blo_q;
					end
				end
				S_CLAMP_HI: begin
					if (acc_q > bhi_q) begin
						acc_q <= bhi_q;
					end
				end
				S_SUM_PI: begin
					last_q  <= err_q;
					fresh_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (state_clear) begin
				acc_q   <= '0;
				last_q  <= '0;
				fresh_q <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					err_q <= $signed({measured[31], measured}) - $signed({target[31], target});
					dt_q  <= step_time;
				end
			end
			S_PROP:    diff_q <= $signed({err_q[32], err_q}) - $signed({last_q[32], last_q});
			S_ACC_MUL: p_q <= from_mag({16'b0, mul_prod[63:16]}, kp_q[31] ^ err_q[32]);
			S_DIV_LO: begin
				if (div_stat.done) begin
					blo_q <= from_mag(div_quo, lower_q[31] ^ ki_q[31]);
				end
			end
			S_DIV_HI: begin
				if (div_stat.done) begin
					bhi_q <= from_mag(div_quo, upper_q[31] ^ ki_q[31]);
				end
			end
			S_ORDER: begin
				// a negative gain flips the bounds
				if (bhi_q < blo_q) begin
					blo_q <= bhi_q;
					bhi_q <= blo_q;
				end
			end
			S_IMUL_LO: imag_q <= mul_prod;
			S_ITERM:   imag_q <= imag_q + {32'b0, mul_prod[63:32]};
			S_ISIGN: begin
				i_q <= from_mag(imag_q, ki_q[31] ^ acc_q[63]);
				d_q <= '0;
			end
			S_DMUL_HI: imag_q <= mul_prod;
			S_DWAIT: begin
				if (div_stat.done) begin
					d_q <= from_mag(div_quo, kd_q[31] ^ diff_q[33]);
				end
			end
			S_SUM_PI:  t_q <= sat_add(p_q, i_q);
			S_SUM_D:   t_q <= sat_add(t_q, d_q);
			S_LIM_LO: begin
				if (t_q < lower_ext) begin
					t_q <= lower_ext;
				end
			end
			S_LIM_HI: begin
				if (load_out) begin
					drive_q <= (t_q > upper_ext) ? upper_q : t_q[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	`PSC_NEVER(a_div_start_busy, clk, arst_n, div_start && div_stat.busy)
	`PSC_ASSERT(a_drive_upper, clk, arst_n, load_out |=> (drive <= $past(upper_q)))
	`PSC_ASSERT(a_fresh_drop, clk, arst_n, load_out |=> !fresh_q)

endmodule
